@@ sv/dscp_pkg.sv @@
// ----------------------------------------------------------------------------
// dscp_pkg
// Shared constants, types and the reply table of the serial command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dscp_pkg;

  localparam int LINE_MAX_DEF = 255;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int HEADER_W    = 7;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_MAIN = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_ALT  = 1'd1;
  localparam logic [HEADER_W-1:0] HEADER_MAIN_RST = 7'd3;
  localparam logic [HEADER_W-1:0] HEADER_ALT_RST  = 7'd33;

  // character codes
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [6:0] CH_NUL  = 7'h00;
  localparam logic [6:0] CH_0    = 7'h30;
  localparam logic [6:0] CH_9    = 7'h39;
  localparam logic [6:0] CH_SEMI = 7'h3B;
  localparam logic [6:0] CH_1    = 7'h31;
  localparam logic [6:0] CH_2    = 7'h32;
  localparam logic [6:0] CH_4    = 7'h34;
  localparam logic [6:0] CH_8    = 7'h38;
  localparam logic [6:0] CH_A    = 7'h41;
  localparam logic [6:0] CH_B    = 7'h42;
  localparam logic [6:0] CH_D    = 7'h44;
  localparam logic [6:0] CH_G    = 7'h47;
  localparam logic [6:0] CH_J    = 7'h4A;
  localparam logic [6:0] CH_N    = 7'h4E;
  localparam logic [6:0] CH_P    = 7'h50;
  localparam logic [6:0] CH_R    = 7'h52;

  // field numbers of the telemetry body
  localparam logic [1:0] FIELD_SPEED = 2'd0;
  localparam logic [1:0] FIELD_RPM   = 2'd1;
  localparam logic [1:0] FIELD_GEAR  = 2'd2;

  // reply table layout
  localparam int ROM_W = 5;
  localparam logic [ROM_W-1:0] ROM_H        = 5'd0;
  localparam logic [ROM_W-1:0] ROM_ONE      = 5'd1;
  localparam logic [ROM_W-1:0] ROM_ZERO     = 5'd2;
  localparam logic [ROM_W-1:0] ROM_THREE    = 5'd3;
  localparam logic [ROM_W-1:0] ROM_NAME     = 5'd4;
  localparam logic [ROM_W-1:0] ROM_NAME_END = 5'd16;
  localparam logic [ROM_W-1:0] ROM_GNP      = 5'd17;
  localparam logic [ROM_W-1:0] ROM_GNP_END  = 5'd20;

  typedef struct packed {
    logic [1:0]  fields;
    logic [15:0] speed;
    logic [15:0] rpm;
    logic [6:0]  gear;
    logic        cancel;
  } dscp_parse_t;

  function automatic logic [7:0] reply_rom(input logic [ROM_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h68;
      5'd1:    b = 8'h01;
      5'd2:    b = 8'h00;
      5'd3:    b = 8'h03;
      5'd4:    b = 8'h70;
      5'd5:    b = 8'h69;
      5'd6:    b = 8'h63;
      5'd7:    b = 8'h6F;
      5'd8:    b = 8'h20;
      5'd9:    b = 8'h45;
      5'd10:   b = 8'h56;
      5'd11:   b = 8'h45;
      5'd12:   b = 8'h20;
      5'd13:   b = 8'h44;
      5'd14:   b = 8'h61;
      5'd15:   b = 8'h73;
      5'd16:   b = 8'h68;
      5'd17:   b = 8'h47;
      5'd18:   b = 8'h4E;
      5'd19:   b = 8'h50;
      5'd20:   b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ sv/dscp_in_if.sv @@
// ----------------------------------------------------------------------------
// dscp_in_if
// Received byte channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dscp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ sv/dscp_out_if.sv @@
// ----------------------------------------------------------------------------
// dscp_out_if
// Result channel: reply bytes and telemetry updates.
// ----------------------------------------------------------------------------
`default_nettype none

interface dscp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  reply_byte;
  logic [15:0] speed_value;
  logic [15:0] rpm_value;
  logic [6:0]  gear_char;
  logic        last;

  modport source (output valid, output kind, output reply_byte, output speed_value,
                  output rpm_value, output gear_char, output last, input ready);
  modport sink (input valid, input kind, input reply_byte, input speed_value,
                input rpm_value, input gear_char, input last, output ready);
endinterface

`default_nettype wire

@@ sv/dscp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// dscp_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dscp_cfg_if
  import dscp_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [HEADER_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/dscp_line_store.sv @@
// ----------------------------------------------------------------------------
// dscp_line_store
// Line buffer memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dscp_line_store
  import dscp_pkg::*;
#(
  parameter int DEPTH = LINE_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [6:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [6:0]               rd_data
);

  logic [6:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/dscp_field_acc.sv @@
// ----------------------------------------------------------------------------
// dscp_field_acc
// Telemetry body scanner: splits fields at semicolons and accumulates the
// leading decimal digits through one shared multiply-by-ten adder.
// ----------------------------------------------------------------------------
`default_nettype none

module dscp_field_acc
  import dscp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        clr,
  input  logic        step,
  input  logic [6:0]  ch,
  output dscp_parse_t res
);

  logic [1:0]  fields;
  logic [15:0] speed;
  logic [15:0] rpm;
  logic [6:0]  gear;
  logic        gear_seen;
  logic        num_open;
  logic        cancel;

  logic        is_digit;
  logic        is_semi;
  logic        kept;
  logic [15:0] acc_cur;
  logic [15:0] acc_next;

  assign is_digit = (ch >= CH_0) && (ch <= CH_9);
  assign is_semi  = (ch == CH_SEMI);
  assign kept     = is_digit || is_semi || (ch == CH_N) || (ch == CH_R) ||
                    (ch == CH_P) || (ch == CH_D);

  // shared multiply-add for the current numeric field
  assign acc_cur  = (fields == FIELD_SPEED) ? speed : rpm;
  assign acc_next = (acc_cur << 3) + (acc_cur << 1) + {12'd0, ch[3:0]};

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      fields    <= FIELD_SPEED;
      speed     <= 16'd0;
      rpm       <= 16'd0;
      gear      <= 7'd0;
      gear_seen <= 1'b0;
      num_open  <= 1'b1;
      cancel    <= 1'b0;
    end else if (step) begin
      if (ch == CH_G) begin
        cancel <= 1'b1;
      end
      if (kept) begin
        if (is_semi && (fields != FIELD_GEAR)) begin
          fields   <= fields + 2'd1;
          num_open <= 1'b1;
        end else if (fields == FIELD_GEAR) begin
          if (!gear_seen) begin
            gear      <= ch;
            gear_seen <= 1'b1;
          end
        end else if (num_open) begin
          if (is_digit) begin
            if (fields == FIELD_SPEED) begin
              speed <= acc_next;
            end else begin
              rpm <= acc_next;
            end
          end else begin
            num_open <= 1'b0;
          end
        end
      end
    end
  end

  assign res.fields = fields;
  assign res.speed  = speed;
  assign res.rpm    = rpm;
  assign res.gear   = gear_seen ? gear : 7'd0;
  assign res.cancel = cancel;

endmodule

`default_nettype wire

@@ sv/dashboard_serial_command_parser.sv @@
// ----------------------------------------------------------------------------
// dashboard_serial_command_parser
// Line-based serial command parser with reply and telemetry output.
// ----------------------------------------------------------------------------
// A received byte other than carriage return is stored while there is room,
// and rx ready stays high. A carriage return ending a non-empty line starts
// the line sequencer, and rx ready stays low until the line is finished:
// header and selector reads through the single read port of the line buffer
// (S_HDR0, S_HDR1, S_CMD, plus S_GEAR on a gear line), up to 13 reply beats,
// a buffer read then a shared field accumulator step per body character of
// a 'P' line, a commit step and one telemetry beat; the result side can stall
// the beats. The line buffer has no reset; only entries written in the
// current line are used. Results pass through a one-beat output register.
`default_nettype none

module dashboard_serial_command_parser
  import dscp_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dscp_in_if.sink    rx,
  dscp_out_if.source result,
  dscp_cfg_if.sink   cfg
);

  localparam int COUNT_W = $clog2(LINE_MAX + 1);
  localparam int ADDR_W  = $clog2(LINE_MAX);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR0,
    S_HDR1,
    S_CMD,
    S_GEAR,
    S_REPLY,
    S_SCAN_RD,
    S_SCAN_USE,
    S_COMMIT,
    S_TELEM
  } state_t;

  state_t              state;
  logic [COUNT_W-1:0]  line_count;
  logic [COUNT_W-1:0]  line_len;
  logic [COUNT_W-1:0]  scan_idx;
  logic [6:0]          hdr;
  logic [HEADER_W-1:0] header_main;
  logic [HEADER_W-1:0] header_alt;
  logic [15:0]         speed_reg;
  logic [15:0]         rpm_reg;
  logic [6:0]          gear_reg;
  logic [ROM_W-1:0]    rom_idx;
  logic [ROM_W-1:0]    rom_end;
  logic                is_parse;

  logic                out_valid;
  logic                out_kind;
  logic [7:0]          out_reply;
  logic [15:0]         out_speed;
  logic [15:0]         out_rpm;
  logic [6:0]          out_gear;
  logic                out_last;

  logic                out_free;
  logic                rx_take;
  logic                wr_en;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [6:0]          rd_data;
  logic                hdr_ok;
  logic                cmd_hit;
  logic [ROM_W-1:0]    cmd_first;
  logic [ROM_W-1:0]    cmd_last;
  logic                scan_end;
  dscp_parse_t         parse_res;

  assign out_free  = !out_valid || result.ready;
  assign rx.ready  = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rx_take   = rx.valid && rx.ready;
  assign wr_en     = rx_take && (rx.rx_byte != CH_CR) &&
                     (line_count < COUNT_W'(LINE_MAX));

  // read address for each sequencer step
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (state)
      S_HDR0:    rd_addr = ADDR_W'(0);
      S_HDR1:    rd_addr = ADDR_W'(1);
      S_CMD:     rd_addr = ADDR_W'(2);
      S_SCAN_RD: rd_addr = scan_idx[ADDR_W-1:0];
      default:   rd_en   = 1'b0;
    endcase
  end

  dscp_line_store #(
    .DEPTH (LINE_MAX)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (line_count[ADDR_W-1:0]),
    .wr_data (rx.rx_byte[6:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dscp_field_acc u_acc (
    .clk  (clk),
    .rst  (rst),
    .clr  (state == S_CMD),
    .step (state == S_SCAN_USE),
    .ch   (rd_data),
    .res  (parse_res)
  );

  // selector decode, rd_data holds the second character in S_CMD
  assign hdr_ok = (hdr == header_main) || (hdr == header_alt);

  always_comb begin
    cmd_hit   = 1'b1;
    cmd_first = ROM_ONE;
    cmd_last  = ROM_ONE;
    case (rd_data)
      CH_1: begin
        cmd_first = ROM_H;
        cmd_last  = ROM_H;
      end
      CH_8: begin
        cmd_first = ROM_ONE;
        cmd_last  = ROM_ONE;
      end
      CH_J, CH_2, CH_B, CH_4: begin
        cmd_first = ROM_ZERO;
        cmd_last  = ROM_ZERO;
      end
      CH_A: begin
        cmd_first = ROM_THREE;
        cmd_last  = ROM_THREE;
      end
      CH_N: begin
        cmd_first = ROM_NAME;
        cmd_last  = ROM_NAME_END;
      end
      CH_0: begin
        cmd_first = ROM_GNP;
        cmd_last  = ROM_GNP_END;
      end
      CH_G, CH_P: begin
        cmd_first = ROM_ONE;
        cmd_last  = ROM_ONE;
      end
      default: cmd_hit = 1'b0;
    endcase
  end

  assign scan_end = (rd_data == CH_NUL) || (rd_data == CH_G) ||
                    ((scan_idx + COUNT_W'(1)) == line_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      line_count  <= '0;
      line_len    <= '0;
      scan_idx    <= '0;
      header_main <= HEADER_MAIN_RST;
      header_alt  <= HEADER_ALT_RST;
      speed_reg   <= 16'd0;
      rpm_reg     <= 16'd0;
      gear_reg    <= 7'd0;
      rom_idx     <= '0;
      rom_end     <= '0;
      is_parse    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_HEADER_MAIN: header_main <= cfg.data;
          REG_HEADER_ALT:  header_alt  <= cfg.data;
          default: ;
        endcase
      end

      if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (rx_take) begin
            if (rx.rx_byte != CH_CR) begin
              if (wr_en) begin
                line_count <= line_count + COUNT_W'(1);
              end
            end else begin
              line_len   <= line_count;
              line_count <= '0;
              if (line_count >= COUNT_W'(2)) begin
                state <= S_HDR0;
              end else if (line_count != '0) begin
                state <= S_TELEM;
              end
            end
          end
        end
        S_HDR0: begin
          state <= S_HDR1;
        end
        S_HDR1: begin
          hdr   <= rd_data;
          state <= S_CMD;
        end
        S_CMD: begin
          is_parse <= (rd_data == CH_P);
          rom_idx  <= cmd_first;
          rom_end  <= cmd_last;
          if (hdr_ok && cmd_hit) begin
            if (rd_data == CH_G) begin
              if (line_len >= COUNT_W'(3)) begin
                state <= S_GEAR;
              end else begin
                gear_reg <= 7'd0;
                state    <= S_REPLY;
              end
            end else begin
              state <= S_REPLY;
            end
          end else begin
            state <= S_TELEM;
          end
        end
        S_GEAR: begin
          gear_reg <= rd_data;
          state    <= S_REPLY;
        end
        S_REPLY: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= 1'b0;
            out_reply <= reply_rom(rom_idx);
            out_speed <= 16'd0;
            out_rpm   <= 16'd0;
            out_gear  <= 7'd0;
            out_last  <= 1'b0;
            if (rom_idx == rom_end) begin
              if (is_parse && (line_len > COUNT_W'(2))) begin
                scan_idx <= COUNT_W'(2);
                state    <= S_SCAN_RD;
              end else begin
                state <= S_TELEM;
              end
            end else begin
              rom_idx <= rom_idx + ROM_W'(1);
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_USE;
        end
        S_SCAN_USE: begin
          if (scan_end) begin
            state <= S_COMMIT;
          end else begin
            scan_idx <= scan_idx + COUNT_W'(1);
            state    <= S_SCAN_RD;
          end
        end
        S_COMMIT: begin
          if (!parse_res.cancel) begin
            speed_reg <= parse_res.speed;
            if (parse_res.fields != FIELD_SPEED) begin
              rpm_reg <= parse_res.rpm;
            end
            if (parse_res.fields == FIELD_GEAR) begin
              gear_reg <= parse_res.gear;
            end
          end
          state <= S_TELEM;
        end
        S_TELEM: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= 1'b1;
            out_reply <= 8'd0;
            out_speed <= speed_reg;
            out_rpm   <= rpm_reg;
            out_gear  <= gear_reg;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_kind;
  assign result.reply_byte  = out_reply;
  assign result.speed_value = out_speed;
  assign result.rpm_value   = out_rpm;
  assign result.gear_char   = out_gear;
  assign result.last        = out_last;

endmodule

`default_nettype wire
